[rtl/cvs_pkg.sv]
// Shared types, codes and constants of the 3x3 RGB stream convolver.
package cvs_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int COEF_BITS_DEF  = 16;

	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int TAP_SLOT    = 16;
	localparam int SUM_W       = 28;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int DIM_W       = 11;
	localparam int STRIDE_W    = 4;
	localparam int QUEUE_DEPTH = 8;

	localparam int RST_WIDTH    = 640;
	localparam int RST_HEIGHT   = 480;
	localparam int RST_STRIDE   = 1;
	// middle row, right slot
	localparam int RST_UNIT_TAP = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_TOP = 3'd0,
		CFG_COEF_MID = 3'd1,
		CFG_COEF_BOT = 3'd2,
		CFG_WIDTH    = 3'd3,
		CFG_HEIGHT   = 3'd4,
		CFG_STRIDE   = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} mark_t;

	typedef struct packed {
		sum_t sum_blue;
		sum_t sum_green;
		sum_t sum_red;
		logic row_end;
		logic frame_end;
	} result_t;

endpackage

[rtl/cvs_line_mem.sv]
// Line store: one write port, one registered read port with write-through.
module cvs_line_mem #(
	parameter int DEPTH = cvs_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [cvs_pkg::PIX_W-1:0]   wdata,
	input  logic [AW-1:0]               raddr,
	output logic [cvs_pkg::PIX_W-1:0]   rdata
);

	logic [cvs_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/cvs_lane.sv]
// One channel lane: nine tap products, group sums and the window total.
module cvs_lane #(
	parameter int COEF_BITS = cvs_pkg::COEF_BITS_DEF
) (
	input  logic                             clk,
	input  logic [cvs_pkg::CH_W-1:0]         pix [9],
	input  logic signed [COEF_BITS-1:0]      tap [9],
	output cvs_pkg::sum_t                    sum
);

	localparam int PW = COEF_BITS + cvs_pkg::CH_W + 1;

	logic signed [PW-1:0]   prod_s2 [9];
	logic signed [PW+1:0]   grp_s3 [3];
	logic signed [PW+3:0]   total;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			prod_s2[k] <= $signed({1'b0, pix[k]}) * tap[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 3; g++) begin
			grp_s3[g] <= (PW+2)'(prod_s2[3*g]) + (PW+2)'(prod_s2[3*g+1])
				+ (PW+2)'(prod_s2[3*g+2]);
		end
	end

	assign total = (PW+4)'(grp_s3[0]) + (PW+4)'(grp_s3[1]) + (PW+4)'(grp_s3[2]);

	always_ff @(posedge clk) begin
		sum <= cvs_pkg::SUM_W'(total);
	end

endmodule

[rtl/cvs_pos.sv]
// Output position check: stride hits and row/frame end marks over two stages.
module cvs_pos #(
	parameter int MAX_WIDTH  = cvs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cvs_pkg::MAX_HEIGHT_DEF,
	localparam int VB = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
		$clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT),
	localparam int WB = $clog2(MAX_WIDTH + 1),
	localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                            clk,
	input  logic                            fire,
	input  logic [VB-1:0]                   r,
	input  logic [VB-1:0]                   c,
	input  logic [cvs_pkg::STRIDE_W-1:0]    stride,
	input  logic [WB-1:0]                   w_c,
	input  logic [HB-1:0]                   h_c,
	output cvs_pkg::mark_t                  mark
);

	localparam int K     = VB + 4;
	localparam int MB    = K + 1;
	localparam int TWO_K = 1 << K;

	localparam logic [MB-1:0] RECIP [16] = '{
		MB'(TWO_K),            MB'(TWO_K),            MB'((TWO_K + 1) / 2),
		MB'((TWO_K + 2) / 3),  MB'((TWO_K + 3) / 4),  MB'((TWO_K + 4) / 5),
		MB'((TWO_K + 5) / 6),  MB'((TWO_K + 6) / 7),  MB'((TWO_K + 7) / 8),
		MB'((TWO_K + 8) / 9),  MB'((TWO_K + 9) / 10), MB'((TWO_K + 10) / 11),
		MB'((TWO_K + 11) / 12), MB'((TWO_K + 12) / 13), MB'((TWO_K + 13) / 14),
		MB'((TWO_K + 14) / 15)
	};

	logic [VB+MB-1:0]   rp_s2;
	logic [VB+MB-1:0]   cp_s2;
	logic [VB-1:0]      r_s2;
	logic [VB-1:0]      c_s2;
	logic               fire_s2;
	logic [VB-1:0]      rq;
	logic [VB-1:0]      cq;
	logic               rhit;
	logic               chit;
	logic               r_last;
	logic               c_last;

	always_ff @(posedge clk) begin
		rp_s2   <= r * RECIP[stride];
		cp_s2   <= c * RECIP[stride];
		r_s2    <= r;
		c_s2    <= c;
		fire_s2 <= fire;
	end

	always_comb begin
		rq     = rp_s2[K +: VB];
		cq     = cp_s2[K +: VB];
		rhit   = ((VB+4)'(rq) * (VB+4)'(stride)) == (VB+4)'(r_s2);
		chit   = ((VB+4)'(cq) * (VB+4)'(stride)) == (VB+4)'(c_s2);
		r_last = ((VB+1)'(r_s2) + (VB+1)'(stride)) >= (VB+1)'(h_c);
		c_last = ((VB+1)'(c_s2) + (VB+1)'(stride)) >= (VB+1)'(w_c);
	end

	always_ff @(posedge clk) begin
		mark.emit      <= fire_s2 && rhit && chit;
		mark.row_end   <= chit && c_last;
		mark.frame_end <= chit && c_last && rhit && r_last;
	end

endmodule

[rtl/cvs_res_queue.sv]
// Result queue between the lane pipeline and the result channel.
module cvs_res_queue #(
	parameter int DEPTH = cvs_pkg::QUEUE_DEPTH,
	localparam int PB = $clog2(DEPTH),
	localparam int CB = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cvs_pkg::result_t    wdata,
	input  logic                pop,
	output logic                valid,
	output cvs_pkg::result_t    rdata
);

	cvs_pkg::result_t   mem_q [DEPTH];
	logic [PB-1:0]      wr_ptr_q;
	logic [PB-1:0]      rd_ptr_q;
	logic [CB-1:0]      cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(DEPTH - 1)) ? '0 : wr_ptr_q + PB'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(DEPTH - 1)) ? '0 : rd_ptr_q + PB'(1);
			end
			cnt_q <= cnt_q + CB'(push) - CB'(pop);
		end
	end

	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

endmodule

[rtl/conv3x3_rgb_stream_unit.sv]
// Top level of the 3x3 zero-padded strided RGB stream convolver.
//
// channel  dir  handshake              payload
// pixel    in   px_valid / px_stall    op, pixel_blue, pixel_green, pixel_red
// result   out  res_valid / res_stall  sum_blue, sum_green, sum_red, row_end, frame_end
// config   in   cfg_we                 cfg_index, cfg_data
//
// One request per clock while px_stall is low; window build, lane products, group sums and
// totals form a four-stage pipeline whose emitted results are written to the result queue.
// An eight-entry result queue parts the lanes from the result channel; px_stall rises
// while eight requests are in the pipeline or queued.
// Reset clears counters, window column registers, queue and registers to their defaults; the two line
// stores are not cleared and are masked on the top rows.
module conv3x3_rgb_stream_unit #(
	parameter int MAX_WIDTH  = cvs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cvs_pkg::MAX_HEIGHT_DEF,
	parameter int COEF_BITS  = cvs_pkg::COEF_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                px_valid,
	output logic                                px_stall,
	input  logic                                op,
	input  logic [cvs_pkg::CH_W-1:0]            pixel_blue,
	input  logic [cvs_pkg::CH_W-1:0]            pixel_green,
	input  logic [cvs_pkg::CH_W-1:0]            pixel_red,
	output logic                                res_valid,
	input  logic                                res_stall,
	output cvs_pkg::sum_t                       sum_blue,
	output cvs_pkg::sum_t                       sum_green,
	output cvs_pkg::sum_t                       sum_red,
	output logic                                row_end,
	output logic                                frame_end,
	input  logic                                cfg_we,
	input  logic [cvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int XB = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int YB = $clog2(MAX_HEIGHT + 2);
	localparam int VB = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
		$clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
	localparam int QD    = cvs_pkg::QUEUE_DEPTH;
	localparam int OCC_W = $clog2(QD + 1);
	localparam int PW    = cvs_pkg::PIX_W;

	logic signed [COEF_BITS-1:0]        tap_q [9];
	logic [cvs_pkg::DIM_W-1:0]          width_q;
	logic [cvs_pkg::DIM_W-1:0]          height_q;
	logic [cvs_pkg::STRIDE_W-1:0]       stride_q;
	logic [WB-1:0]                      w_c;
	logic [HB-1:0]                      h_c;
	logic [cvs_pkg::STRIDE_W-1:0]       s_eff;

	logic [XB-1:0]      x_q;
	logic [YB-1:0]      y_q;
	logic [XB-1:0]      x_nx;
	logic [YB-1:0]      y_nx;
	logic               acc;
	logic               x0;
	logic               y_ge1;
	logic               y_ge2;
	logic               y_lt_h;
	logic               y_le_h;
	logic               y_le_h1;
	logic               y_end;
	logic               x_wrap;
	logic               fire;
	logic [VB-1:0]      r_pos;
	logic [VB-1:0]      c_pos;

	logic [PW-1:0]      px;
	logic [PW-1:0]      rd1;
	logic [PW-1:0]      rd2;
	logic [PW-1:0]      col [3];
	logic [PW-1:0]      wr0_q [3];
	logic [PW-1:0]      wr1_q [3];
	logic [XB-1:0]      rd_addr;
	logic               line_we;

	logic [PW-1:0]      win_s1 [3][3];
	logic               fire_s1;
	logic [VB-1:0]      r_s1;
	logic [VB-1:0]      c_s1;
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               v_s4;
	cvs_pkg::mark_t     mark_s3;
	cvs_pkg::mark_t     mark_s4;

	logic [cvs_pkg::CH_W-1:0]   lane_pix [3][9];
	cvs_pkg::sum_t              lane_sum [3];

	logic [OCC_W-1:0]   occ_q;
	logic               push;
	logic               drop;
	logic               pop;
	cvs_pkg::result_t   res_in;
	cvs_pkg::result_t   res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				tap_q[k] <= '0;
			end
			tap_q[cvs_pkg::RST_UNIT_TAP] <= COEF_BITS'(1);
			width_q  <= cvs_pkg::DIM_W'(cvs_pkg::RST_WIDTH);
			height_q <= cvs_pkg::DIM_W'(cvs_pkg::RST_HEIGHT);
			stride_q <= cvs_pkg::STRIDE_W'(cvs_pkg::RST_STRIDE);
		end else if (cfg_we) begin
			case (cvs_pkg::cfg_idx_t'(cfg_index))
				cvs_pkg::CFG_COEF_TOP: begin
					for (int k = 0; k < 3; k++) begin
						tap_q[k] <= cfg_data[cvs_pkg::TAP_SLOT*k +: COEF_BITS];
					end
				end
				cvs_pkg::CFG_COEF_MID: begin
					for (int k = 0; k < 3; k++) begin
						tap_q[3+k] <= cfg_data[cvs_pkg::TAP_SLOT*k +: COEF_BITS];
					end
				end
				cvs_pkg::CFG_COEF_BOT: begin
					for (int k = 0; k < 3; k++) begin
						tap_q[6+k] <= cfg_data[cvs_pkg::TAP_SLOT*k +: COEF_BITS];
					end
				end
				cvs_pkg::CFG_WIDTH:  width_q  <= cfg_data[cvs_pkg::DIM_W-1:0];
				cvs_pkg::CFG_HEIGHT: height_q <= cfg_data[cvs_pkg::DIM_W-1:0];
				cvs_pkg::CFG_STRIDE: stride_q <= cfg_data[cvs_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry
	always_comb begin
		if (width_q == '0) begin
			w_c = WB'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_c = WB'(MAX_WIDTH);
		end else begin
			w_c = WB'(width_q);
		end
		if (height_q == '0) begin
			h_c = HB'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_c = HB'(MAX_HEIGHT);
		end else begin
			h_c = HB'(height_q);
		end
		s_eff = (stride_q == '0) ? cvs_pkg::STRIDE_W'(1) : stride_q;
	end

	assign acc = px_valid && !px_stall;

	// raster position and window front end
	always_comb begin
		x0      = (x_q == '0);
		y_ge1   = (y_q != '0);
		y_ge2   = (y_q > YB'(1));
		y_lt_h  = (YB+1)'(y_q) < (YB+1)'(h_c);
		y_le_h  = (YB+1)'(y_q) <= (YB+1)'(h_c);
		y_le_h1 = (YB+1)'(y_q) <= (YB+1)'(h_c) + (YB+1)'(1);
		y_end   = !y_le_h1 || ((YB+1)'(y_q) == (YB+1)'(h_c) + (YB+1)'(1));
		x_wrap  = ((WB+1)'(x_q) + (WB+1)'(1)) >= (WB+1)'(w_c);

		if (y_end) begin
			x_nx = '0;
			y_nx = '0;
		end else if (x_wrap) begin
			x_nx = '0;
			y_nx = y_q + YB'(1);
		end else begin
			x_nx = x_q + XB'(1);
			y_nx = y_q;
		end

		if (x0) begin
			fire  = y_ge2 && y_le_h1;
			r_pos = VB'(y_q - YB'(2));
			c_pos = VB'(w_c - WB'(1));
		end else begin
			fire  = y_ge1 && y_le_h && ((WB+1)'(x_q) < (WB+1)'(w_c));
			r_pos = VB'(y_q - YB'(1));
			c_pos = VB'(x_q - XB'(1));
		end

		if (y_lt_h && (cvs_pkg::op_t'(op) == cvs_pkg::OP_PIXEL)) begin
			px = {pixel_red, pixel_green, pixel_blue};
		end else begin
			px = '0;
		end
		col[0] = y_ge2 ? rd2 : '0;
		col[1] = y_ge1 ? rd1 : '0;
		col[2] = px;

		rd_addr = acc ? x_nx : x_q;
		line_we = acc && y_le_h;
	end

	cvs_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_one (
		.clk   (clk),
		.we    (line_we),
		.waddr (x_q),
		.wdata (px),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	cvs_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_two (
		.clk   (clk),
		.we    (line_we),
		.waddr (x_q),
		.wdata (rd1),
		.raddr (rd_addr),
		.rdata (rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			for (int k = 0; k < 3; k++) begin
				wr0_q[k] <= '0;
				wr1_q[k] <= '0;
			end
		end else if (acc) begin
			x_q <= x_nx;
			y_q <= y_nx;
			for (int k = 0; k < 3; k++) begin
				wr0_q[k] <= x0 ? '0 : wr1_q[k];
				wr1_q[k] <= col[k];
			end
		end
	end

	// stage 1: window capture
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < 3; k++) begin
				win_s1[0][k] <= wr0_q[k];
				win_s1[1][k] <= wr1_q[k];
				win_s1[2][k] <= x0 ? '0 : col[k];
			end
			fire_s1 <= fire;
			r_s1    <= r_pos;
			c_s1    <= c_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// channel lanes
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int rr = 0; rr < 3; rr++) begin
				for (int cc = 0; cc < 3; cc++) begin
					lane_pix[ch][3*rr+cc] = win_s1[cc][rr][cvs_pkg::CH_W*ch +: cvs_pkg::CH_W];
				end
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		cvs_lane #(
			.COEF_BITS (COEF_BITS)
		) u_lane (
			.clk (clk),
			.pix (lane_pix[ch]),
			.tap (tap_q),
			.sum (lane_sum[ch])
		);
	end

	cvs_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk    (clk),
		.fire   (fire_s1),
		.r      (r_s1),
		.c      (c_s1),
		.stride (s_eff),
		.w_c    (w_c),
		.h_c    (h_c),
		.mark   (mark_s3)
	);

	always_ff @(posedge clk) begin
		mark_s4 <= mark_s3;
	end

	// merge lanes and marks into the result queue
	always_comb begin
		push   = v_s4 && mark_s4.emit;
		drop   = v_s4 && !mark_s4.emit;
		pop    = res_valid && !res_stall;
		res_in = '{
			sum_blue:  lane_sum[0],
			sum_green: lane_sum[1],
			sum_red:   lane_sum[2],
			row_end:   mark_s4.row_end,
			frame_end: mark_s4.frame_end
		};
	end

	cvs_res_queue #(
		.DEPTH (QD)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res_in),
		.pop    (pop),
		.valid  (res_valid),
		.rdata  (res_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc) - OCC_W'(drop) - OCC_W'(pop);
		end
	end

	assign px_stall  = (occ_q >= OCC_W'(QD));
	assign sum_blue  = res_out.sum_blue;
	assign sum_green = res_out.sum_green;
	assign sum_red   = res_out.sum_red;
	assign row_end   = res_out.row_end;
	assign frame_end = res_out.frame_end;

	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> row_end)
		else $error("frame end without row end");

	a_empty_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !res_valid)
		else $error("result offered with nothing in flight");

	a_flush_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && y_end |=> (x_q == '0) && (y_q == '0))
		else $error("frame did not restart after flush request");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		px_stall |-> !$past(acc) || ($past(occ_q) == OCC_W'(QD - 1)) || $past(px_stall))
		else $error("occupancy jumped past the queue depth");

endmodule
